// ----- rtl/lca_pkg.sv -----
// Shared constants, codes and types for the linear classifier core.
`default_nettype none
package lca_pkg;

  localparam int MAX_CLASSES_DEF  = 16;
  localparam int MAX_FEATURES_DEF = 256;

  localparam int OUT_LIMIT  = 16;
  localparam int CLS_W      = 4;
  localparam int CC_W       = 5;
  localparam int FC_W       = 9;
  localparam int KIND_W     = 2;
  localparam int INDEX_W    = 12;
  localparam int SAMPLE_W   = 16;
  localparam int PROD_W     = 32;
  localparam int ACC_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [KIND_W-1:0] KIND_WEIGHT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BIAS    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FEATURE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_ENABLE   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_MARGIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             load_w;
    logic             load_b;
    logic             cap_x;
    logic             issue;
    logic [CLS_W-1:0] cls;
    logic             seed;
    logic             track;
    logic [FC_W-1:0]  nf;
    logic [FC_W-1:0]  fpos;
    logic             bias_en;
    logic             calc_margin;
    logic             emit;
    logic             emit_last;
  } dp_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/lca_ctrl.sv -----
// Controller: configuration registers, feature position and the run sequencer.
`default_nettype none
module lca_ctrl import lca_pkg::*; #(
  parameter int MAX_CLASSES  = MAX_CLASSES_DEF,
  parameter int MAX_FEATURES = MAX_FEATURES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [KIND_W-1:0]     in_kind,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output dp_cmd_t                    cmd
);

  localparam int CLS_LIM = (MAX_CLASSES < OUT_LIMIT) ? MAX_CLASSES : OUT_LIMIT;

  state_t           state_r, state_nxt;
  logic [CLS_W-1:0] cls_r, cls_nxt;
  logic [1:0]       drain_r, drain_nxt;
  logic [FC_W-1:0]  pos_r, pos_nxt;
  logic [CC_W-1:0]  cc_r, cc_nxt;
  logic [FC_W-1:0]  fc_r, fc_nxt;
  logic             be_r, be_nxt;
  logic [FC_W-1:0]  fcur_r;
  logic             seed_r;
  logic             lastf_r;

  logic [CC_W-1:0]  nc_m1_w;
  logic [CLS_W-1:0] nc_m1;
  logic [FC_W-1:0]  nf;
  logic [FC_W-1:0]  f;
  logic             f_last;
  logic             accept;
  logic             feat_acc;

  // effective sizes, clamped into the supported range
  always_comb begin
    if (cc_r == '0) begin
      nc_m1_w = '0;
    end else if (cc_r > CC_W'(CLS_LIM)) begin
      nc_m1_w = CC_W'(CLS_LIM - 1);
    end else begin
      nc_m1_w = cc_r - CC_W'(1);
    end
    nc_m1 = nc_m1_w[CLS_W-1:0];

    if (fc_r == '0) begin
      nf = FC_W'(1);
    end else if (32'(fc_r) > MAX_FEATURES) begin
      nf = FC_W'(MAX_FEATURES);
    end else begin
      nf = fc_r;
    end
  end

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign feat_acc = accept && (in_kind == KIND_FEATURE);
  assign f        = (pos_r >= nf) ? '0 : pos_r;
  assign f_last   = (f == nf - FC_W'(1));

  // config registers and feature position
  always_comb begin
    cc_nxt  = cc_r;
    fc_nxt  = fc_r;
    be_nxt  = be_r;
    pos_nxt = pos_r;
    if (feat_acc) begin
      pos_nxt = f_last ? '0 : f + FC_W'(1);
    end
    if (cfg_we) begin
      unique case (cfg_index)
        REG_CLASS_COUNT: begin
          cc_nxt  = cfg_wdata[CC_W-1:0];
          pos_nxt = '0;
        end
        REG_FEATURE_COUNT: begin
          fc_nxt  = cfg_wdata[FC_W-1:0];
          pos_nxt = '0;
        end
        REG_BIAS_ENABLE: begin
          be_nxt = cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cls_nxt   = cls_r;
    drain_nxt = drain_r;
    unique case (state_r)
      ST_IDLE: begin
        if (feat_acc) begin
          state_nxt = ST_MAC;
          cls_nxt   = '0;
        end
      end
      ST_MAC: begin
        if (cls_r == nc_m1) begin
          state_nxt = ST_DRAIN;
          drain_nxt = '0;
        end else begin
          cls_nxt = cls_r + CLS_W'(1);
        end
      end
      ST_DRAIN: begin
        // drain: product, accumulate, argmax update
        drain_nxt = drain_r + 2'd1;
        if (drain_r == 2'd2) begin
          state_nxt = lastf_r ? ST_MARGIN : ST_IDLE;
        end
      end
      ST_MARGIN: begin
        state_nxt = ST_EMIT;
        cls_nxt   = '0;
      end
      ST_EMIT: begin
        if (cls_r == nc_m1) begin
          state_nxt = ST_IDLE;
        end else begin
          cls_nxt = cls_r + CLS_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath commands
  always_comb begin
    cmd             = '0;
    cmd.load_w      = accept && (in_kind == KIND_WEIGHT);
    cmd.load_b      = accept && (in_kind == KIND_BIAS);
    cmd.cap_x       = feat_acc;
    cmd.cls         = cls_r;
    cmd.seed        = seed_r;
    cmd.track       = lastf_r;
    cmd.nf          = nf;
    cmd.fpos        = fcur_r;
    cmd.bias_en     = be_r;
    unique case (state_r)
      ST_MAC: begin
        cmd.issue = 1'b1;
      end
      ST_MARGIN: begin
        cmd.calc_margin = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit      = 1'b1;
        cmd.emit_last = (cls_r == nc_m1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cls_r   <= '0;
      drain_r <= '0;
      pos_r   <= '0;
      cc_r    <= CC_W'(2);
      fc_r    <= FC_W'(1);
      be_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cls_r   <= cls_nxt;
      drain_r <= drain_nxt;
      pos_r   <= pos_nxt;
      cc_r    <= cc_nxt;
      fc_r    <= fc_nxt;
      be_r    <= be_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (feat_acc) begin
      fcur_r  <= f;
      seed_r  <= (f == '0);
      lastf_r <= f_last;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lca_dp.sv -----
// Datapath: weight, bias and accumulator memories, shared MAC pipe, argmax tracker.
`default_nettype none
module lca_dp import lca_pkg::*; #(
  parameter int MAX_CLASSES  = MAX_CLASSES_DEF,
  parameter int MAX_FEATURES = MAX_FEATURES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire dp_cmd_t                    cmd,
  input  wire logic [INDEX_W-1:0]         in_index,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  input  wire logic signed [ACC_W-1:0]    in_bias_value,
  output logic                            out_valid,
  output logic [CLS_W-1:0]                out_class_index,
  output logic signed [ACC_W-1:0]         out_score,
  output logic                            out_last,
  output logic [CLS_W-1:0]                out_predicted_class,
  output logic signed [ACC_W-1:0]         out_top_score,
  output logic signed [ACC_W-1:0]         out_margin
);

  localparam int WS_DEPTH = MAX_CLASSES * MAX_FEATURES;
  localparam int WA_W     = $clog2(WS_DEPTH);
  localparam int CA_W     = $clog2(MAX_CLASSES);

  logic [SAMPLE_W-1:0] wmem [WS_DEPTH];
  logic [ACC_W-1:0]    bmem [MAX_CLASSES];
  logic [ACC_W-1:0]    amem [MAX_CLASSES];

  logic [WA_W-1:0]     waddr_r;
  logic [WA_W-1:0]     rd_waddr;
  logic                w_ok, b_ok;
  logic [CA_W-1:0]     rd_cls;

  logic signed [SAMPLE_W-1:0] x_r;
  logic [SAMPLE_W-1:0] w_q;
  logic [ACC_W-1:0]    b_q;
  logic [ACC_W-1:0]    a_q;

  logic                s1_v_r;
  logic [CLS_W-1:0]    s1_cls_r;
  logic                s1_seed_r, s1_trk_r;

  logic                s2_v_r;
  logic [CLS_W-1:0]    s2_cls_r;
  logic                s2_trk_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]    base_r;
  logic [ACC_W-1:0]    sum;

  logic                t_v_r;
  logic [CLS_W-1:0]    t_cls_r;
  logic [ACC_W-1:0]    t_val_r;

  logic [ACC_W-1:0]    best_r, second_r, margin_r;
  logic [CLS_W-1:0]    bidx_r;

  logic                o_v_r, o_last_r;
  logic [CLS_W-1:0]    o_cls_r, o_pred_r;
  logic [ACC_W-1:0]    o_best_r, o_marg_r;

  assign w_ok     = (32'(in_index) < WS_DEPTH);
  assign b_ok     = (32'(in_index) < MAX_CLASSES);
  // weight for class c sits at c*nf + f: step by nf per class
  assign rd_waddr = (cmd.cls == '0) ? WA_W'(cmd.fpos) : waddr_r + WA_W'(cmd.nf);
  assign rd_cls   = CA_W'(cmd.cls);

  always_ff @(posedge clk) begin
    if (cmd.load_w && w_ok) begin
      wmem[WA_W'(in_index)] <= in_sample;
    end
    if (cmd.issue) begin
      w_q     <= wmem[rd_waddr];
      waddr_r <= rd_waddr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_b && b_ok) begin
      bmem[CA_W'(in_index)] <= in_bias_value;
    end
    if (cmd.issue) begin
      b_q <= bmem[rd_cls];
    end
  end

  // accumulators: one read port shared by MAC issue and result readout
  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      amem[CA_W'(s2_cls_r)] <= sum;
    end
    if (cmd.issue || cmd.emit) begin
      a_q <= amem[rd_cls];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_x) begin
      x_r <= in_sample;
    end
  end

  // stage 1: multiply, pick the accumulator base
  always_ff @(posedge clk) begin
    s1_cls_r  <= cmd.cls;
    s1_seed_r <= cmd.seed;
    s1_trk_r  <= cmd.track;
    s2_cls_r  <= s1_cls_r;
    s2_trk_r  <= s1_trk_r;
    prod_r    <= $signed(w_q) * x_r;
    if (s1_seed_r) begin
      base_r <= cmd.bias_en ? b_q : '0;
    end else begin
      base_r <= a_q;
    end
  end

  // stage 2: wrapping accumulate
  assign sum = base_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    t_cls_r <= s2_cls_r;
    t_val_r <= sum;
  end

  // running best / second best over final scores; ties keep the lower class
  always_ff @(posedge clk) begin
    if (t_v_r) begin
      if (t_cls_r == '0) begin
        best_r   <= t_val_r;
        second_r <= t_val_r;
        bidx_r   <= '0;
      end else if ($signed(t_val_r) > $signed(best_r)) begin
        second_r <= best_r;
        best_r   <= t_val_r;
        bidx_r   <= t_cls_r;
      end else if ((t_cls_r == CLS_W'(1)) || ($signed(t_val_r) > $signed(second_r))) begin
        second_r <= t_val_r;
      end
    end
    if (cmd.calc_margin) begin
      margin_r <= best_r - second_r;
    end
  end

  always_ff @(posedge clk) begin
    o_cls_r  <= cmd.cls;
    o_pred_r <= cmd.emit_last ? bidx_r : '0;
    o_best_r <= cmd.emit_last ? best_r : '0;
    o_marg_r <= cmd.emit_last ? margin_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      t_v_r    <= 1'b0;
      o_v_r    <= 1'b0;
      o_last_r <= 1'b0;
    end else begin
      s1_v_r   <= cmd.issue;
      s2_v_r   <= s1_v_r;
      t_v_r    <= s2_v_r && s2_trk_r;
      o_v_r    <= cmd.emit;
      o_last_r <= cmd.emit && cmd.emit_last;
    end
  end

  assign out_valid           = o_v_r;
  assign out_class_index     = o_cls_r;
  assign out_score           = a_q;
  assign out_last            = o_last_r;
  assign out_predicted_class = o_pred_r;
  assign out_top_score       = o_best_r;
  assign out_margin          = o_marg_r;

endmodule
`default_nettype wire

// ----- rtl/linear_classifier_argmax_core.sv -----
// Linear classifier top level: Q15 weights and features, 64-bit scores, argmax.
// One multiply-accumulate unit is shared by all classes, one class per cycle.
// A load (weight or bias) completes in the cycle in which it is accepted. A
// feature passes through the accept, MAC issue for each class in use, and a
// drain of the product, accumulate and argmax stages. The last feature of a
// vector adds a margin step and then the results: they come out on
// consecutive cycles with out_valid high, class 0 first, and out_last on the
// final one, which also carries predicted class, best score and margin (these
// read zero otherwise). The receiver cannot hold results off. busy falls while
// the final result is shown, so the next item may be taken in that cycle.
`default_nettype none
module linear_classifier_argmax_core import lca_pkg::*; #(
  parameter int MAX_CLASSES  = MAX_CLASSES_DEF,
  parameter int MAX_FEATURES = MAX_FEATURES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [KIND_W-1:0]          in_kind,
  input  wire logic [INDEX_W-1:0]         in_index,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  input  wire logic signed [ACC_W-1:0]    in_bias_value,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_wdata,
  output logic                            out_valid,
  output logic [CLS_W-1:0]                out_class_index,
  output logic signed [ACC_W-1:0]         out_score,
  output logic                            out_last,
  output logic [CLS_W-1:0]                out_predicted_class,
  output logic signed [ACC_W-1:0]         out_top_score,
  output logic signed [ACC_W-1:0]         out_margin
);

  dp_cmd_t cmd;

  lca_ctrl #(
    .MAX_CLASSES  (MAX_CLASSES),
    .MAX_FEATURES (MAX_FEATURES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_kind   (in_kind),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd)
  );

  lca_dp #(
    .MAX_CLASSES  (MAX_CLASSES),
    .MAX_FEATURES (MAX_FEATURES)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_index            (in_index),
    .in_sample           (in_sample),
    .in_bias_value       (in_bias_value),
    .out_valid           (out_valid),
    .out_class_index     (out_class_index),
    .out_score           (out_score),
    .out_last            (out_last),
    .out_predicted_class (out_predicted_class),
    .out_top_score       (out_top_score),
    .out_margin          (out_margin)
  );

endmodule
`default_nettype wire

// ----- rtl/lca_chk.sv -----
// Port-level checker for the classifier core, bound to the top level.
`default_nettype none
module lca_chk import lca_pkg::*; (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic [KIND_W-1:0]          in_kind,
  input wire logic                       out_valid,
  input wire logic [CLS_W-1:0]           out_class_index,
  input wire logic                       out_last,
  input wire logic [CLS_W-1:0]           out_predicted_class,
  input wire logic signed [ACC_W-1:0]    out_top_score,
  input wire logic signed [ACC_W-1:0]    out_margin
);

  // a feature transfer always starts work
  a_feat_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_kind == KIND_FEATURE) |=> busy)
    else $error("feature transfer did not raise busy");

  // a burst of results starts at class 0
  a_first_cls: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> (out_class_index == '0))
    else $error("result burst does not start at class 0");

  // results of one run come back to back in class order
  a_next_cls: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=>
      out_valid && (out_class_index == CLS_W'($past(out_class_index) + CLS_W'(1))))
    else $error("result burst broken or out of order");

  // the final result closes the burst
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("result after final result");

  // summary fields are zero except on the final result
  a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |->
      (out_predicted_class == '0) && (out_top_score == '0) && (out_margin == '0))
    else $error("summary fields set on a non-final result");

endmodule

bind linear_classifier_argmax_core lca_chk u_lca_chk (.*);
`default_nettype wire
